// ----- design/lzw_pkg.sv -----
// Shared types and constants for the LZW trie compressor.
// Used by lzw_ctrl, lzw_datapath and lzw_trie_compressor; no dependencies.
package lzw_pkg;

    localparam int ROOT_COUNT = 256;
    localparam int LETTER_W   = 8;
    localparam int CODE_W     = 9;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_EMIT,
        ST_LINK
    } lzw_state_t;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch letter, read child head of current node
        logic rd_head;   // follow child head link, read that node
        logic rd_sib;    // follow sibling link, read that node
        logic match;     // move current node to the matched child
        logic emit;      // load result, allocate fresh node unless full or block ends, restart at root
        logic link_wr;   // hook the fresh node into its parent's list
    } lzw_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic head_zero;  // current node has no children
        logic hit;        // node just read holds the letter
        logic sib_zero;   // node just read is the tail of its list
        logic out_free;   // result register can take a word this cycle
        logic will_alloc; // a miss now adds a node
    } lzw_status_t;

endpackage

// ----- design/lzw_ctrl.sv -----
// Sequencer for the LZW trie compressor: one letter at a time through
// head read, sibling walk, emit and link. Depends on lzw_pkg.
module lzw_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 letter_valid,
    output logic                 letter_stall,
    input  lzw_pkg::lzw_status_t stat,
    output lzw_pkg::lzw_cmd_t    cmd
);
    import lzw_pkg::*;

    lzw_state_t state_reg;
    lzw_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (letter_valid)
                begin
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                state_next = stat.head_zero ? ST_EMIT : ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (stat.sib_zero)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.will_alloc ? ST_LINK : ST_IDLE;
                end
            end
            ST_LINK:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd          = '0;
        letter_stall = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                letter_stall = 1'b0;
                cmd.capture  = letter_valid;
            end
            ST_HEAD:
            begin
                cmd.rd_head = !stat.head_zero;
            end
            ST_WALK:
            begin
                cmd.match  = stat.hit;
                cmd.rd_sib = !stat.hit && !stat.sib_zero;
            end
            ST_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            ST_LINK:
            begin
                cmd.link_wr = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ----- design/lzw_datapath.sv -----
// Trie storage, walk registers, counters and result register of the
// LZW trie compressor. Driven by lzw_ctrl; depends on lzw_pkg.
module lzw_datapath #(
    parameter int DICT_DEPTH  = 512,
    parameter int BLOCK_CODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [lzw_pkg::LETTER_W-1:0]  letter_in,
    input  lzw_pkg::lzw_cmd_t             cmd,
    output lzw_pkg::lzw_status_t          stat,
    output logic                          code_valid,
    input  logic                          code_stall,
    output logic [lzw_pkg::CODE_W-1:0]    code_out,
    output logic                          block_end
);
    import lzw_pkg::*;

    localparam int NODE_W    = $clog2(DICT_DEPTH);
    localparam int TOT_W     = $clog2(DICT_DEPTH + 1);
    localparam int CNT_W     = $clog2(BLOCK_CODES + 1);
    localparam int MEM_DEPTH = DICT_DEPTH - ROOT_COUNT;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int ROOT_AW   = $clog2(ROOT_COUNT);

    localparam logic [NODE_W-1:0] ROOT_BASE  = NODE_W'(ROOT_COUNT);
    localparam logic [TOT_W-1:0]  TOTAL_INIT = TOT_W'(ROOT_COUNT);
    localparam logic [TOT_W-1:0]  TOTAL_MAX  = TOT_W'(DICT_DEPTH);
    localparam logic [CNT_W-1:0]  CODES_LAST = CNT_W'(BLOCK_CODES - 1);

    // non-root nodes, addressed by node index minus ROOT_COUNT
    logic [LETTER_W-1:0] letter_mem [MEM_DEPTH];
    logic [NODE_W-1:0]   sib_mem    [MEM_DEPTH];
    logic [NODE_W-1:0]   child_mem  [MEM_DEPTH];
    // child head of each root, valid bits cleared on reset and block end
    logic [NODE_W-1:0]   root_child_mem [ROOT_COUNT];
    logic [ROOT_COUNT-1:0] root_vld_reg;

    logic [LETTER_W-1:0] letter_rd_reg;
    logic [NODE_W-1:0]   sib_rd_reg;
    logic [NODE_W-1:0]   child_rd_reg;
    logic [NODE_W-1:0]   root_child_rd_reg;
    logic                root_vld_rd_reg;

    logic [LETTER_W-1:0] letter_reg, letter_next;
    logic [NODE_W-1:0]   cur_reg, cur_next;
    logic [NODE_W-1:0]   link_reg, link_next;
    logic [NODE_W-1:0]   parent_reg, parent_next;
    logic [NODE_W-1:0]   fresh_reg, fresh_next;
    logic                has_tail_reg, has_tail_next;
    logic [TOT_W-1:0]    node_total_reg, node_total_next;
    logic [CNT_W-1:0]    codes_reg, codes_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   code_reg, code_next;
    logic                end_reg, end_next;

    logic                cur_is_root;
    logic                parent_is_root;
    logic                dict_full;
    logic                last_code;
    logic                out_free;
    logic                will_alloc;
    logic [NODE_W-1:0]   head_link;
    logic [NODE_W-1:0]   node_addr;
    logic [NODE_W-1:0]   fresh_node;
    logic [NODE_W-1:0]   cur_off_full;
    logic [NODE_W-1:0]   parent_off_full;
    logic [NODE_W-1:0]   node_off_full;
    logic [NODE_W-1:0]   fresh_off_full;
    logic [NODE_W-1:0]   tail_off_full;
    logic [MEM_AW-1:0]   cur_off;
    logic [MEM_AW-1:0]   parent_off;
    logic [MEM_AW-1:0]   node_off;
    logic [MEM_AW-1:0]   fresh_off;
    logic [MEM_AW-1:0]   tail_off;
    logic                root_link_wr;
    logic                child_link_wr;
    logic                sib_link_wr;
    logic                alloc_wr;

    assign cur_is_root    = (cur_reg[NODE_W-1:ROOT_AW] == '0);
    assign parent_is_root = (parent_reg[NODE_W-1:ROOT_AW] == '0);
    assign dict_full      = (node_total_reg == TOTAL_MAX);
    assign last_code      = (codes_reg == CODES_LAST);
    assign out_free       = !out_valid_reg || !code_stall;
    assign will_alloc     = !dict_full && !last_code;
    assign head_link      = cur_is_root ? (root_vld_rd_reg ? root_child_rd_reg : '0)
                                        : child_rd_reg;
    assign node_addr      = cmd.rd_head ? head_link : sib_rd_reg;
    assign fresh_node     = node_total_reg[NODE_W-1:0];

    assign cur_off_full    = cur_reg - ROOT_BASE;
    assign parent_off_full = parent_reg - ROOT_BASE;
    assign node_off_full   = node_addr - ROOT_BASE;
    assign fresh_off_full  = fresh_node - ROOT_BASE;
    assign tail_off_full   = link_reg - ROOT_BASE;
    assign cur_off         = cur_off_full[MEM_AW-1:0];
    assign parent_off      = parent_off_full[MEM_AW-1:0];
    assign node_off        = node_off_full[MEM_AW-1:0];
    assign fresh_off       = fresh_off_full[MEM_AW-1:0];
    assign tail_off        = tail_off_full[MEM_AW-1:0];

    assign alloc_wr      = cmd.emit && will_alloc;
    assign sib_link_wr   = cmd.link_wr && has_tail_reg;
    assign root_link_wr  = cmd.link_wr && !has_tail_reg && parent_is_root;
    assign child_link_wr = cmd.link_wr && !has_tail_reg && !parent_is_root;

    assign stat.head_zero  = (head_link == '0);
    assign stat.hit        = (letter_rd_reg == letter_reg);
    assign stat.sib_zero   = (sib_rd_reg == '0);
    assign stat.out_free   = out_free;
    assign stat.will_alloc = will_alloc;

    assign code_valid = out_valid_reg;
    assign code_out   = code_reg;
    assign block_end  = end_reg;

    // root child heads
    always_ff @(posedge clk)
    begin
        if (root_link_wr)
        begin
            root_child_mem[parent_reg[ROOT_AW-1:0]] <= fresh_reg;
        end
        if (cmd.capture)
        begin
            root_child_rd_reg <= root_child_mem[cur_reg[ROOT_AW-1:0]];
            root_vld_rd_reg   <= root_vld_reg[cur_reg[ROOT_AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_vld_reg <= '0;
        end
        else if (cmd.emit && last_code)
        begin
            root_vld_reg <= '0;
        end
        else if (root_link_wr)
        begin
            root_vld_reg[parent_reg[ROOT_AW-1:0]] <= 1'b1;
        end
    end

    // non-root node fields
    always_ff @(posedge clk)
    begin
        if (alloc_wr)
        begin
            letter_mem[fresh_off] <= letter_reg;
        end
        if (cmd.rd_head || cmd.rd_sib)
        begin
            letter_rd_reg <= letter_mem[node_off];
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_wr)
        begin
            sib_mem[fresh_off] <= '0;
        end
        else if (sib_link_wr)
        begin
            sib_mem[tail_off] <= fresh_reg;
        end
        if (cmd.rd_head || cmd.rd_sib)
        begin
            sib_rd_reg <= sib_mem[node_off];
        end
    end

    always_ff @(posedge clk)
    begin
        if (alloc_wr)
        begin
            child_mem[fresh_off] <= '0;
        end
        else if (child_link_wr)
        begin
            child_mem[parent_off] <= fresh_reg;
        end
        if (cmd.capture && !cur_is_root)
        begin
            child_rd_reg <= child_mem[cur_off];
        end
    end

    always_comb
    begin
        letter_next     = letter_reg;
        cur_next        = cur_reg;
        link_next       = link_reg;
        parent_next     = parent_reg;
        fresh_next      = fresh_reg;
        has_tail_next   = has_tail_reg;
        node_total_next = node_total_reg;
        codes_next      = codes_reg;
        out_valid_next  = out_valid_reg && code_stall;
        code_next       = code_reg;
        end_next        = end_reg;

        if (cmd.capture)
        begin
            letter_next   = letter_in;
            has_tail_next = 1'b0;
        end
        if (cmd.rd_head || cmd.rd_sib)
        begin
            link_next = node_addr;
        end
        if (cmd.rd_head)
        begin
            has_tail_next = 1'b1;
        end
        if (cmd.match)
        begin
            cur_next = link_reg;
        end
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            code_next      = cur_reg[CODE_W-1:0];
            end_next       = last_code;
            parent_next    = cur_reg;
            fresh_next     = fresh_node;
            cur_next       = NODE_W'(letter_reg);
            if (last_code)
            begin
                codes_next      = '0;
                node_total_next = TOTAL_INIT;
            end
            else
            begin
                codes_next = codes_reg + 1'b1;
                if (!dict_full)
                begin
                    node_total_next = node_total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg        <= '0;
            has_tail_reg   <= 1'b0;
            node_total_reg <= TOTAL_INIT;
            codes_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            cur_reg        <= cur_next;
            has_tail_reg   <= has_tail_next;
            node_total_reg <= node_total_next;
            codes_reg      <= codes_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        letter_reg <= letter_next;
        link_reg   <= link_next;
        parent_reg <= parent_next;
        fresh_reg  <= fresh_next;
        code_reg   <= code_next;
        end_reg    <= end_next;
    end

    a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
        (node_total_reg >= TOTAL_INIT) && (node_total_reg <= TOTAL_MAX))
        else $error("node total out of range");

    a_codes_range: assert property (@(posedge clk) disable iff (!rst_n)
        codes_reg <= CODES_LAST)
        else $error("code count passed block length");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> out_free)
        else $error("result loaded over a pending word");

    a_block_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && last_code) |=>
            (node_total_reg == TOTAL_INIT) && (codes_reg == '0) && (root_vld_reg == '0))
        else $error("dictionary not rebuilt after block end");

    a_link_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link_wr |-> $past(alloc_wr))
        else $error("link write without a fresh node");

endmodule

// ----- design/lzw_trie_compressor.sv -----
// Top level of the LZW trie compressor: sequencer plus trie datapath.
// Instantiates lzw_ctrl and lzw_datapath; depends on lzw_pkg.
//
//  channel  | valid         | stall         | payload
//  ---------+---------------+---------------+----------------------------
//  letter   | letter_valid  | letter_stall  | letter_in[7:0]
//  code     | code_valid    | code_stall    | code_out[8:0], block_end
//
// Walk: each letter is captured, the child head of the current node is read,
//   then the sibling walk reads the child list, one node memory read per
//   cycle, until the letter matches or the tail is reached; a miss then emits
//   the code and, when a node is added, links it into its parent's list.
// Reset: asynchronous, active low; the dictionary comes back at once through
//   the root valid bits, so there is no clearing pass.
// Stalls: the code word sits in an output register; letters keep being taken
//   while it waits, and only a second miss holds until the word is taken.
module lzw_trie_compressor #(
    parameter int DICT_DEPTH  = 512,
    parameter int BLOCK_CODES = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          letter_valid,
    output logic                          letter_stall,
    input  logic [lzw_pkg::LETTER_W-1:0]  letter_in,
    output logic                          code_valid,
    input  logic                          code_stall,
    output logic [lzw_pkg::CODE_W-1:0]    code_out,
    output logic                          block_end
);
    import lzw_pkg::*;

    // command and status between sequencer and datapath
    lzw_cmd_t    cmd;
    lzw_status_t stat;

    // sequencer: accept a letter, walk the child list, emit on a miss
    lzw_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .letter_valid (letter_valid),
        .letter_stall (letter_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    // trie memories, walk registers, counters and the output register
    lzw_datapath #(
        .DICT_DEPTH  (DICT_DEPTH),
        .BLOCK_CODES (BLOCK_CODES)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .letter_in  (letter_in),
        .cmd        (cmd),
        .stat       (stat),
        .code_valid (code_valid),
        .code_stall (code_stall),
        .code_out   (code_out),
        .block_end  (block_end)
    );

endmodule
